@@ hdl/tcs_pkg.sv @@
// Shared types and constants of the text console scrollback engine.
package tcs_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_COLOR = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ROW     = 1'd1;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] COLOR_RESET = 8'd7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } t_request;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
        logic        refresh;
        logic [5:0]  view_top_row;
        logic [10:0] cursor_index;
    } t_result;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_BKSP,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [5:0] read_row;
        logic [6:0] read_col;
        logic       in_range;
    } t_cmd;

endpackage

@@ hdl/text_console_scrollback.sv @@
// Top level of the text console engine: front end, command queue and back end.
// A put, backspace or read gives its result from the execute state; a newline adds a refresh
// state, a scrolling newline first blanks one row, a put that wraps on the last row blanks one
// row and then executes again, and a clear blanks the whole store; the store has one write port.
// A two-entry queue takes further items while the back end is busy. After a synchronous reset the
// store is swept, one cell a cycle, without accepting items.
module text_console_scrollback #(
    parameter int SCREEN_COLS   = 80,
    parameter int SCREEN_ROWS   = 25,
    parameter int STORE_ROWS    = 64,
    parameter int RESERVED_ROWS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tcs_pkg::t_request               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tcs_pkg::t_result                o_out_item,
    input  logic                            i_cfg_we,
    input  logic [tcs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic          init_busy;
    logic          queue_ready;
    logic          push;
    tcs_pkg::t_cmd front_cmd;
    logic          pop;
    logic          head_valid;
    tcs_pkg::t_cmd head_cmd;

    tcs_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .STORE_ROWS  (STORE_ROWS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .i_in_item     (i_in_item),
        .i_hold        (init_busy),
        .i_queue_ready (queue_ready),
        .o_in_ready    (o_in_ready),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    tcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_cmd),
        .i_pop   (pop),
        .o_ready (queue_ready),
        .o_valid (head_valid),
        .o_head  (head_cmd)
    );

    tcs_back #(
        .SCREEN_COLS   (SCREEN_COLS),
        .SCREEN_ROWS   (SCREEN_ROWS),
        .STORE_ROWS    (STORE_ROWS),
        .RESERVED_ROWS (RESERVED_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hdl/tcs_front.sv @@
// Front end: accepts request items and classifies them into commands.
module tcs_front #(
    parameter int SCREEN_COLS = 80,
    parameter int STORE_ROWS  = 64
) (
    input  logic              i_in_valid,
    input  tcs_pkg::t_request i_in_item,
    input  logic              i_hold,
    input  logic              i_queue_ready,
    output logic              o_in_ready,
    output logic              o_push,
    output tcs_pkg::t_cmd     o_cmd
);

    assign o_in_ready = i_queue_ready && !i_hold;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.char_code = i_in_item.char_code;
        o_cmd.color     = i_in_item.color;
        o_cmd.read_row  = i_in_item.read_row;
        o_cmd.read_col  = i_in_item.read_col;
        o_cmd.in_range  = (32'(i_in_item.read_row) < STORE_ROWS) &&
                          (32'(i_in_item.read_col) < SCREEN_COLS);
        case (i_in_item.req_type)
            tcs_pkg::REQ_PUT: begin
                if (i_in_item.char_code == tcs_pkg::CH_BACKSPACE) begin
                    o_cmd.op = tcs_pkg::OP_BKSP;
                end else if (i_in_item.char_code == tcs_pkg::CH_NEWLINE) begin
                    o_cmd.op = tcs_pkg::OP_NEWLINE;
                end else begin
                    o_cmd.op = tcs_pkg::OP_PUT;
                end
            end
            tcs_pkg::REQ_CLEAR: o_cmd.op = tcs_pkg::OP_CLEAR;
            tcs_pkg::REQ_READ:  o_cmd.op = tcs_pkg::OP_READ;
            default:            o_cmd.op = tcs_pkg::OP_NOP;
        endcase
    end

endmodule

@@ hdl/tcs_queue.sv @@
// Two-entry command queue between the front end and the back end.
module tcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcs_pkg::t_cmd i_item,
    input  logic          i_pop,
    output logic          o_ready,
    output logic          o_valid,
    output tcs_pkg::t_cmd o_head
);

    tcs_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/tcs_back.sv @@
// Back end: cursor, circular cell store, row fills and result register.
module tcs_back #(
    parameter int SCREEN_COLS   = 80,
    parameter int SCREEN_ROWS   = 25,
    parameter int STORE_ROWS    = 64,
    parameter int RESERVED_ROWS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  tcs_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    input  logic                            i_cfg_we,
    input  logic [tcs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_init_busy,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tcs_pkg::t_result                o_out_item
);

    localparam int RW       = $clog2(STORE_ROWS);
    localparam int CW       = $clog2(SCREEN_COLS);
    localparam int CCW      = $clog2(SCREEN_COLS + 1);
    localparam int WRITABLE = (SCREEN_ROWS > RESERVED_ROWS) ?
                              (SCREEN_ROWS - RESERVED_ROWS) : 1;
    localparam int IDX_MAX  = (WRITABLE - 1) * SCREEN_COLS + SCREEN_COLS;
    localparam int IW       = $clog2(IDX_MAX + 1);

    localparam logic [RW-1:0]  LAST_ROW = RW'(STORE_ROWS - 1);
    localparam logic [RW:0]    ROWS_EXT = (RW + 1)'(STORE_ROWS);
    localparam logic [CW-1:0]  LAST_COL = CW'(SCREEN_COLS - 1);
    localparam logic [CCW-1:0] FULL_COL = CCW'(SCREEN_COLS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_REFRESH
    } t_state;

    t_state           r_state;
    logic             r_init;
    tcs_pkg::t_cmd    r_cmd;
    logic [RW-1:0]    r_base;
    logic [RW-1:0]    r_row;
    logic [CCW-1:0]   r_col;
    logic [7:0]       r_default_color;
    logic [7:0]       r_fill_color;
    logic             r_fill_all;
    logic [RW-1:0]    r_fill_row;
    logic [CW-1:0]    r_fill_col;
    logic             r_out_valid;
    tcs_pkg::t_result r_out_item;
    logic [15:0]      r_rd_data;
    logic [15:0]      r_cells [STORE_ROWS][SCREEN_COLS];

    logic             wrap;
    logic             at_last;
    logic [RW-1:0]    base_next;
    logic             rd_en;
    logic [RW-1:0]    rd_row;
    logic [CW-1:0]    rd_col;
    logic             mem_we;
    logic [RW-1:0]    mem_wrow;
    logic [CW-1:0]    mem_wcol;
    logic [15:0]      mem_wdata;
    logic             below;
    logic [RW-1:0]    view_top;
    logic [RW-1:0]    view_line;
    logic [IW-1:0]    flat_idx;
    tcs_pkg::t_result refresh_item;
    tcs_pkg::t_result read_item;
    logic             fill_last_col;
    logic             fill_done;

    function automatic logic [RW-1:0] to_phys(input logic [RW-1:0] row,
                                              input logic [RW-1:0] base);
        logic [RW:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= ROWS_EXT) begin
            sum = sum - ROWS_EXT;
        end
        return sum[RW-1:0];
    endfunction

    assign wrap      = (r_col == FULL_COL);
    assign at_last   = (r_row == LAST_ROW);
    assign base_next = (r_base == LAST_ROW) ? '0 : r_base + RW'(1);

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid &&
                       (!r_out_valid || i_out_ready);
    assign rd_en     = o_cmd_pop && (i_cmd.op == tcs_pkg::OP_READ) && i_cmd.in_range;
    assign rd_row    = to_phys(RW'(i_cmd.read_row), r_base);
    assign rd_col    = CW'(i_cmd.read_col);

    always_comb begin
        mem_we    = 1'b0;
        mem_wrow  = to_phys(wrap ? r_row + RW'(1) : r_row, r_base);
        mem_wcol  = wrap ? '0 : CW'(r_col);
        mem_wdata = {r_cmd.color, r_cmd.char_code};
        if (r_state == S_FILL) begin
            mem_we    = 1'b1;
            mem_wrow  = r_fill_row;
            mem_wcol  = r_fill_col;
            mem_wdata = {r_fill_color, tcs_pkg::CH_SPACE};
        end else if (r_state == S_EXEC && r_cmd.op == tcs_pkg::OP_PUT) begin
            mem_we = !(wrap && at_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_wrow][mem_wcol] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_cells[rd_row][rd_col];
        end
    end

    always_comb begin
        below     = (32'(r_row) >= WRITABLE);
        view_top  = below ? r_row - RW'(WRITABLE - 1) : '0;
        view_line = below ? RW'(WRITABLE - 1) : r_row;
        flat_idx  = IW'(view_line) * IW'(SCREEN_COLS) + IW'(r_col);

        refresh_item              = '0;
        refresh_item.refresh      = 1'b1;
        refresh_item.view_top_row = 6'(view_top);
        refresh_item.cursor_index = 11'(flat_idx);

        read_item = '0;
        if (r_cmd.in_range) begin
            read_item.cell_char  = r_rd_data[7:0];
            read_item.cell_color = r_rd_data[15:8];
        end
    end

    assign fill_last_col = (r_fill_col == LAST_COL);
    assign fill_done     = fill_last_col && (!r_fill_all || r_fill_row == LAST_ROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_FILL;
            r_init          <= 1'b1;
            r_base          <= '0;
            r_row           <= '0;
            r_col           <= '0;
            r_default_color <= tcs_pkg::COLOR_RESET;
            r_fill_color    <= tcs_pkg::COLOR_RESET;
            r_fill_all      <= 1'b1;
            r_fill_row      <= '0;
            r_fill_col      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd.op)
                        tcs_pkg::OP_PUT: begin
                            if (wrap && at_last) begin
                                r_base       <= base_next;
                                r_fill_row   <= r_base;
                                r_fill_col   <= '0;
                                r_fill_all   <= 1'b0;
                                r_fill_color <= r_default_color;
                                r_col        <= '0;
                                r_state      <= S_FILL;
                            end else begin
                                if (wrap) begin
                                    r_row <= r_row + RW'(1);
                                    r_col <= CCW'(1);
                                end else begin
                                    r_col <= r_col + CCW'(1);
                                end
                                r_out_valid <= 1'b1;
                                r_out_item  <= '0;
                                r_state     <= S_IDLE;
                            end
                        end
                        tcs_pkg::OP_BKSP: begin
                            if (r_col != '0) begin
                                r_col <= r_col - CCW'(1);
                            end else if (r_row != '0) begin
                                r_row <= r_row - RW'(1);
                                r_col <= CCW'(SCREEN_COLS - 1);
                            end
                            r_out_valid <= 1'b1;
                            r_out_item  <= '0;
                            r_state     <= S_IDLE;
                        end
                        tcs_pkg::OP_NEWLINE: begin
                            r_col <= '0;
                            if (at_last) begin
                                r_base       <= base_next;
                                r_fill_row   <= r_base;
                                r_fill_col   <= '0;
                                r_fill_all   <= 1'b0;
                                r_fill_color <= r_default_color;
                                r_state      <= S_FILL;
                            end else begin
                                r_row   <= r_row + RW'(1);
                                r_state <= S_REFRESH;
                            end
                        end
                        tcs_pkg::OP_CLEAR: begin
                            r_base       <= '0;
                            r_row        <= '0;
                            r_col        <= '0;
                            r_fill_row   <= '0;
                            r_fill_col   <= '0;
                            r_fill_all   <= 1'b1;
                            r_fill_color <= r_cmd.color;
                            r_state      <= S_FILL;
                        end
                        tcs_pkg::OP_READ: begin
                            r_out_valid <= 1'b1;
                            r_out_item  <= read_item;
                            r_state     <= S_IDLE;
                        end
                        default: begin
                            r_out_valid <= 1'b1;
                            r_out_item  <= '0;
                            r_state     <= S_IDLE;
                        end
                    endcase
                end
                S_FILL: begin
                    if (fill_done) begin
                        if (r_init) begin
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (r_cmd.op == tcs_pkg::OP_PUT) begin
                            r_state <= S_EXEC;
                        end else begin
                            r_state <= S_REFRESH;
                        end
                    end else if (fill_last_col) begin
                        r_fill_col <= '0;
                        r_fill_row <= r_fill_row + RW'(1);
                    end else begin
                        r_fill_col <= r_fill_col + CW'(1);
                    end
                end
                S_REFRESH: begin
                    r_out_valid <= 1'b1;
                    r_out_item  <= refresh_item;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcs_pkg::REG_DEFAULT_COLOR: begin
                        r_default_color <= i_cfg_data;
                    end
                    tcs_pkg::REG_START_ROW: begin
                        if (32'(i_cfg_data[5:0]) < STORE_ROWS) begin
                            r_row <= RW'(i_cfg_data[5:0]);
                        end else begin
                            r_row <= LAST_ROW;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hdl/tcs_checker.sv @@
// Port-level assertions for the text console engine and their binding.
module tcs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input tcs_pkg::t_result  o_out_item
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("items taken or results shown straight after reset");

    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.refresh |->
            o_out_item.view_top_row == 6'd0 && o_out_item.cursor_index == 11'd0)
        else $error("view or cursor reported without a refresh");

    a_refresh_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.refresh |->
            o_out_item.cell_char == 8'd0 && o_out_item.cell_color == 8'd0)
        else $error("cell data reported with a refresh");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

endmodule

bind text_console_scrollback tcs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

@@ tb/text_console_scrollback_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the text console scrollback engine with a cell-level screen tracker.
module text_console_scrollback_tb;

    localparam int SCREEN_COLS     = 80;
    localparam int SCREEN_ROWS     = 25;
    localparam int STORE_ROWS      = 64;
    localparam int RESERVED_ROWS   = 2;
    localparam int CELL_COUNT      = STORE_ROWS * SCREEN_COLS;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 300;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    class screen_tracker;
        logic [15:0]      cells [CELL_COUNT];
        int unsigned      cur_row;
        int unsigned      cur_col;
        logic [7:0]       blank_color;
        tcs_pkg::t_result due_results [$];
        int unsigned      mismatch_count;
        int unsigned      results_checked;
        int unsigned      refresh_count;
        int unsigned      scroll_count;
        int unsigned      wrap_count;

        function new();
            blank_color = tcs_pkg::COLOR_RESET;
            fill_store(tcs_pkg::COLOR_RESET);
            cur_row = 0;
            cur_col = 0;
            mismatch_count = 0;
            results_checked = 0;
            refresh_count = 0;
            scroll_count = 0;
            wrap_count = 0;
        endfunction

        function void fill_store(logic [7:0] attr);
            for (int i = 0; i < CELL_COUNT; i++) begin
                cells[i] = {attr, tcs_pkg::CH_SPACE};
            end
        endfunction

        function void next_row();
            cur_row++;
            if (cur_row >= STORE_ROWS) begin
                for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++) begin
                    cells[i] = cells[i + SCREEN_COLS];
                end
                for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++) begin
                    cells[i] = {blank_color, tcs_pkg::CH_SPACE};
                end
                cur_row = STORE_ROWS - 1;
                scroll_count++;
            end
        endfunction

        function tcs_pkg::t_result refresh_result();
            tcs_pkg::t_result r;
            int unsigned      shown;
            int unsigned      line;
            r = '0;
            shown = (SCREEN_ROWS > RESERVED_ROWS) ? SCREEN_ROWS - RESERVED_ROWS : 1;
            line = (cur_row >= shown) ? shown - 1 : cur_row;
            r.refresh = 1'b1;
            r.view_top_row = 6'((cur_row >= shown) ? cur_row - shown + 1 : 0);
            r.cursor_index = 11'(line * SCREEN_COLS + cur_col);
            refresh_count++;
            return r;
        endfunction

        function void write_reg(logic [tcs_pkg::CFG_INDEX_W-1:0] index,
                                logic [tcs_pkg::CFG_DATA_W-1:0] value);
            if (index == tcs_pkg::REG_DEFAULT_COLOR) begin
                blank_color = value;
            end else if (index == tcs_pkg::REG_START_ROW) begin
                cur_row = (value[5:0] < STORE_ROWS) ? value[5:0] : STORE_ROWS - 1;
            end
        endfunction

        function void note_request(tcs_pkg::t_request req);
            tcs_pkg::t_result r;
            r = '0;
            case (req.req_type)
                tcs_pkg::REQ_PUT: begin
                    if (req.char_code == tcs_pkg::CH_BACKSPACE) begin
                        if (cur_col > 0) begin
                            if (cur_col > SCREEN_COLS) begin
                                cur_col = SCREEN_COLS;
                            end
                            cur_col--;
                        end else if (cur_row > 0) begin
                            cur_row--;
                            cur_col = SCREEN_COLS - 1;
                        end
                    end else if (req.char_code == tcs_pkg::CH_NEWLINE) begin
                        next_row();
                        cur_col = 0;
                        r = refresh_result();
                    end else begin
                        if (cur_col >= SCREEN_COLS) begin
                            next_row();
                            cur_col = 0;
                            wrap_count++;
                        end
                        cells[cur_row * SCREEN_COLS + cur_col] = {req.color, req.char_code};
                        cur_col++;
                    end
                end
                tcs_pkg::REQ_CLEAR: begin
                    fill_store(req.color);
                    cur_row = 0;
                    cur_col = 0;
                    r = refresh_result();
                end
                tcs_pkg::REQ_READ: begin
                    if (req.read_row < STORE_ROWS && req.read_col < SCREEN_COLS) begin
                        {r.cell_color, r.cell_char} =
                            cells[req.read_row * SCREEN_COLS + req.read_col];
                    end
                end
                default: ;
            endcase
            due_results.push_back(r);
        endfunction

        function void report(string what, tcs_pkg::t_result want, tcs_pkg::t_result got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t %s: expected char %h color %h refresh %b top %0d cursor %0d",
                         $time, what, want.cell_char, want.cell_color, want.refresh,
                         want.view_top_row, want.cursor_index);
                $display("    got char %h color %h refresh %b top %0d cursor %0d",
                         got.cell_char, got.cell_color, got.refresh,
                         got.view_top_row, got.cursor_index);
            end
        endfunction

        function void check_result(tcs_pkg::t_result got);
            tcs_pkg::t_result want;
            want = '0;
            results_checked++;
            if (due_results.size() == 0) begin
                report("result with none outstanding", want, got);
                return;
            end
            want = due_results.pop_front();
            if (got.cell_char !== want.cell_char || got.cell_color !== want.cell_color
                    || got.refresh !== want.refresh
                    || got.view_top_row !== want.view_top_row
                    || got.cursor_index !== want.cursor_index) begin
                report("result differs", want, got);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    tcs_pkg::t_request               in_item;
    logic                            out_valid;
    logic                            out_ready;
    tcs_pkg::t_result                out_item;
    logic                            cfg_we;
    logic [tcs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data;

    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    int unsigned   requests_sent;
    bit            hold_off_wanted;
    bit            hold_off_done;
    screen_tracker screen;

    text_console_scrollback #(
        .SCREEN_COLS  (SCREEN_COLS),
        .SCREEN_ROWS  (SCREEN_ROWS),
        .STORE_ROWS   (STORE_ROWS),
        .RESERVED_ROWS(RESERVED_ROWS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                screen.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready) begin
                screen.note_request(in_item);
            end
            if (out_valid && out_ready) begin
                screen.check_result(out_item);
            end
        end
    end

    initial begin : receiver
        out_ready = 1'b0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_wanted && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] glyph();
        logic [7:0] ch;
        ch = any_byte();
        if (ch == tcs_pkg::CH_BACKSPACE || ch == tcs_pkg::CH_NEWLINE) begin
            ch = tcs_pkg::CH_SPACE;
        end
        return ch;
    endfunction

    function automatic tcs_pkg::t_request make_req(logic [1:0] kind, logic [7:0] ch,
                                                   logic [7:0] attr, logic [5:0] row,
                                                   logic [6:0] col);
        tcs_pkg::t_request req;
        req.req_type = kind;
        req.char_code = ch;
        req.color = attr;
        req.read_row = row;
        req.read_col = col;
        return req;
    endfunction

    task automatic send_request(input tcs_pkg::t_request req);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic put(input logic [7:0] ch, input logic [7:0] attr);
        send_request(make_req(tcs_pkg::REQ_PUT, ch, attr, 6'($urandom_range(63)),
                              7'($urandom_range(127))));
    endtask

    task automatic read_cell(input logic [5:0] row, input logic [6:0] col);
        send_request(make_req(tcs_pkg::REQ_READ, any_byte(), any_byte(), row, col));
    endtask

    task automatic clear_screen(input logic [7:0] attr);
        send_request(make_req(tcs_pkg::REQ_CLEAR, any_byte(), attr, 6'($urandom_range(63)),
                              7'($urandom_range(127))));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (screen.due_results.size() != 0);
    endtask

    task automatic configure(input logic [7:0] attr, input logic [5:0] row);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= tcs_pkg::REG_DEFAULT_COLOR;
        cfg_data <= attr;
        @(posedge clk);
        cfg_index <= tcs_pkg::REG_START_ROW;
        cfg_data <= {2'b00, row};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic text_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            read_cell(6'(screen.cur_row), 7'($urandom_range(SCREEN_COLS - 1)));
        end else if (pick < 14) begin
            read_cell(6'($urandom_range(63)), 7'($urandom_range(127)));
        end else if (pick < 20) begin
            put(tcs_pkg::CH_BACKSPACE, any_byte());
        end else begin
            put(glyph(), any_byte());
        end
    endtask

    task automatic run_phase(input logic [7:0] attr, input logic [5:0] row,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input bit pressure);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        configure(attr, row);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        hold_off_wanted = pressure;
        stop_at = requests_sent + PHASE_ITEMS;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                clear_screen(any_byte());
            end else if (pick < 8) begin
                send_request(make_req(2'($urandom_range(3)), any_byte(), any_byte(),
                                      6'($urandom_range(63)), 7'($urandom_range(127))));
            end else if (pick < 23) begin
                repeat ($urandom_range(8, 1)) put(tcs_pkg::CH_NEWLINE, any_byte());
            end else if (pick < 38) begin
                put(tcs_pkg::CH_NEWLINE, any_byte());
                repeat (SCREEN_COLS) put(glyph(), any_byte());
                if ($urandom_range(1)) begin
                    put(tcs_pkg::CH_BACKSPACE, any_byte());
                end
            end else begin
                len = (pick < 58) ? $urandom_range(100, 70) : $urandom_range(20, 0);
                repeat (len) text_item();
                if ($urandom_range(9) < 7) begin
                    put(tcs_pkg::CH_NEWLINE, any_byte());
                end
            end
        end
    endtask

    initial begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        requests_sent = 0;
        hold_off_wanted = 1'b0;
        screen = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        read_cell(6'd0, 7'd0);
        read_cell(6'd0, 7'd127);
        put(8'h00, 8'h00);
        put(8'hFF, 8'hFF);
        put(tcs_pkg::CH_BACKSPACE, 8'h00);
        put(8'h5A, 8'hA5);
        read_cell(6'd0, 7'd1);
        read_cell(6'd63, 7'd79);
        put(tcs_pkg::CH_NEWLINE, 8'hFF);
        put(tcs_pkg::CH_BACKSPACE, 8'hFF);
        put(8'h21, 8'h3C);
        put(8'h71, 8'hC3);
        read_cell(6'd1, 7'd0);
        send_request(make_req(REQ_UNKNOWN, 8'hFF, 8'hFF, 6'h3F, 7'h7F));
        clear_screen(8'h1E);
        put(tcs_pkg::CH_BACKSPACE, 8'h00);
        read_cell(6'd5, 7'd40);
        put(8'h7F, 8'h80);

        configure(8'hC3, 6'd63);
        put(8'h78, 8'h4B);
        put(tcs_pkg::CH_NEWLINE, 8'h00);
        read_cell(6'd63, 7'd0);
        read_cell(6'd62, 7'd0);
        put(tcs_pkg::CH_BACKSPACE, 8'h00);

        run_phase(8'h00, 6'd50, 0, 0, 1'b1);
        run_phase(8'hFF, 6'd63, 81, 0, 1'b0);
        run_phase(any_byte(), 6'd0, 0, 81, 1'b0);
        run_phase(any_byte(), 6'($urandom_range(63, 20)), 38, 38, 1'b0);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (20) @(posedge clk);

        $display("Sent %0d items and checked %0d results: %0d refreshes, %0d scrolls, %0d wraps.",
                 requests_sent, screen.results_checked, screen.refresh_count,
                 screen.scroll_count, screen.wrap_count);
        $display("Five register settings, a long output hold-off and four idling patterns ran.");
        if (screen.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Mismatches: %0d", screen.mismatch_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
